// ----- hw/rtl/ddc_pkg.sv -----
package ddc_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 12;
    localparam int CENT_W  = 6;   // year / 100 for a 12-bit year
    localparam int LEAP_W  = 10;  // leap years in 1..year
    localparam int BASE_W  = 21;  // 365 * year
    localparam int DOY_W   = 9;   // days before month
    localparam int ORD_W   = 21;  // day ordinal
    localparam int DAYS_W  = 20;
    localparam int LEAPS_W = 9;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 32;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // 1/25 scaled by 2^15, exact for quotients below 1024
    localparam int RECIP25     = 1311;
    localparam int RECIP_SHIFT = 15;

    localparam logic [DAYS_W-1:0]  DAYS_MAX  = '1;
    localparam logic [LEAPS_W-1:0] LEAPS_MAX = '1;

    typedef struct packed {
        logic [DAY_W-1:0]   sd;
        logic [MONTH_W-1:0] sm;
        logic [YEAR_W-1:0]  sy;
        logic [DAY_W-1:0]   ed;
        logic [MONTH_W-1:0] em;
        logic [YEAR_W-1:0]  ey;
        logic [CENT_W-1:0]  cent_s;
        logic [CENT_W-1:0]  cent_e;
        logic [CENT_W-1:0]  cent_sm1;
        logic [CENT_W-1:0]  cent_em1;
    } s1_t;

    typedef struct packed {
        logic               date_ok;
        logic               count_ok;
        logic [BASE_W-1:0]  base_s;
        logic [BASE_W-1:0]  base_e;
        logic [LEAP_W-1:0]  lu_s;
        logic [LEAP_W-1:0]  lu_e;
        logic [DOY_W-1:0]   doy_s;
        logic [DOY_W-1:0]   doy_e;
        logic               feb_s;
        logic               feb_e;
        logic [DAY_W-1:0]   sd;
        logic [DAY_W-1:0]   ed;
    } s2_t;

    typedef struct packed {
        logic               date_ok;
        logic               count_ok;
        logic [ORD_W-1:0]   ord_s;
        logic [ORD_W-1:0]   ord_e;
        logic [LEAP_W-1:0]  leaps;
    } s3_t;

    function automatic logic [CENT_W-1:0] div100(input logic [YEAR_W-1:0] y);
        logic [YEAR_W-3:0]     q4;
        logic [YEAR_W+8:0]     prod;
        begin
            q4   = y[YEAR_W-1:2];
            prod = 21'(q4) * 21'(RECIP25);
            div100 = prod[RECIP_SHIFT +: CENT_W];
        end
    endfunction

    function automatic logic is_leap(input logic [YEAR_W-1:0] y,
                                     input logic [CENT_W-1:0] c);
        logic [YEAR_W:0] hundreds;
        begin
            hundreds = 13'(c) * 13'd100;
            is_leap  = (y[1:0] == 2'b00) &&
                       ((13'(y) != hundreds) || (c[1:0] == 2'b00));
        end
    endfunction

    function automatic logic [LEAP_W-1:0] leaps_upto(input logic [YEAR_W-1:0] n,
                                                     input logic [CENT_W-1:0] c);
        begin
            leaps_upto = LEAP_W'(n[YEAR_W-1:2]) - LEAP_W'(c) + LEAP_W'(c[CENT_W-1:2]);
        end
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        begin
            case (m)
                4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
                MONTH_FEB:               month_len = 5'd28;
                default:                 month_len = 5'd31;
            endcase
        end
    endfunction

    function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        begin
            case (m)
                4'd2:    days_before = 9'd31;
                4'd3:    days_before = 9'd59;
                4'd4:    days_before = 9'd90;
                4'd5:    days_before = 9'd120;
                4'd6:    days_before = 9'd151;
                4'd7:    days_before = 9'd181;
                4'd8:    days_before = 9'd212;
                4'd9:    days_before = 9'd243;
                4'd10:   days_before = 9'd273;
                4'd11:   days_before = 9'd304;
                4'd12:   days_before = 9'd334;
                default: days_before = 9'd0;
            endcase
        end
    endfunction

endpackage

// ----- hw/rtl/date_day_count.sv -----
// Each accepted request passes through four registered stages to the master side.
// Throughput: one request per cycle; the four stages hold their contents
// while the master side stalls and fill any bubble ahead of a stalled stage.
// Reset: rst_n clears every stage valid bit at once; data registers are not
// reset.
module date_day_count #(
    parameter int YEAR_LIMIT = 2100
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // start_day[4:0], start_month[8:5], start_year[20:9],
    // end_day[25:21], end_month[29:26], end_year[41:30], zero fill [47:42]
    input  logic [ddc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // elapsed_days[19:0], leap_years_passed[28:20], zero fill [31:29]
    output logic [ddc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // valid_res[0]
    output logic                           m_axis_tuser
);
    import ddc_pkg::*;

    // Stage valid bits and per-stage enables. A stage loads when it is empty
    // or when the stage after it moves on.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    assign en4 = !v4_reg || m_axis_tready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign s_axis_tready = en1;
    assign m_axis_tvalid = v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= s_axis_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: unpack, clamp the end month, divide the four years of
    // interest by 100 with a reciprocal multiply.
    // ------------------------------------------------------------------
    s1_t s1_reg, s1_next;
    logic [YEAR_W-1:0] in_sy, in_ey, in_sym1, in_eym1;
    logic [MONTH_W-1:0] in_em;

    always_comb
    begin
        in_sy   = s_axis_tdata[20:9];
        in_ey   = s_axis_tdata[41:30];
        in_em   = s_axis_tdata[29:26];
        in_sym1 = in_sy - YEAR_W'(1);
        in_eym1 = in_ey - YEAR_W'(1);

        // an end month of zero counts as January, past December as December
        if (in_em < MONTH_JAN)
            in_em = MONTH_JAN;
        else if (in_em > MONTH_DEC)
            in_em = MONTH_DEC;

        s1_next.sd       = s_axis_tdata[4:0];
        s1_next.sm       = s_axis_tdata[8:5];
        s1_next.sy       = in_sy;
        s1_next.ed       = s_axis_tdata[25:21];
        s1_next.em       = in_em;
        s1_next.ey       = in_ey;
        s1_next.cent_s   = div100(in_sy);
        s1_next.cent_e   = div100(in_ey);
        s1_next.cent_sm1 = div100(in_sym1);
        s1_next.cent_em1 = div100(in_eym1);
    end

    always_ff @(posedge clk)
    begin
        if (en1)
            s1_reg <= s1_next;
    end

    // ------------------------------------------------------------------
    // Stage 2: leap flags, leap counts up to the year before, the 365-day
    // year base, days before month, the start date check and the order test.
    // ------------------------------------------------------------------
    s2_t s2_reg, s2_next;
    logic leap_s, leap_e, month_ok, end_early;
    logic [DAY_W-1:0] mlen;
    logic [YEAR_W-1:0] sym1, eym1;

    always_comb
    begin
        sym1   = s1_reg.sy - YEAR_W'(1);
        eym1   = s1_reg.ey - YEAR_W'(1);
        leap_s = is_leap(s1_reg.sy, s1_reg.cent_s);
        leap_e = is_leap(s1_reg.ey, s1_reg.cent_e);

        month_ok = s1_reg.sm inside {[MONTH_JAN:MONTH_DEC]};
        mlen     = (s1_reg.sm == MONTH_FEB && leap_s) ? 5'd29 : month_len(s1_reg.sm);

        end_early = (s1_reg.ey < s1_reg.sy) ||
                    (s1_reg.ey == s1_reg.sy && s1_reg.em < s1_reg.sm) ||
                    (s1_reg.ey == s1_reg.sy && s1_reg.em == s1_reg.sm &&
                     s1_reg.ed < s1_reg.sd);

        s2_next.date_ok  = (s1_reg.sy != '0) &&
                           ({1'b0, s1_reg.sy} < (YEAR_W+1)'(YEAR_LIMIT)) &&
                           month_ok && (s1_reg.sd != '0) && (s1_reg.sd <= mlen);
        s2_next.count_ok = !end_early;
        s2_next.base_s   = BASE_W'(sym1) * BASE_W'(365);
        s2_next.base_e   = BASE_W'(eym1) * BASE_W'(365);
        s2_next.lu_s     = leaps_upto(sym1, s1_reg.cent_sm1);
        s2_next.lu_e     = leaps_upto(eym1, s1_reg.cent_em1);
        s2_next.doy_s    = days_before(s1_reg.sm);
        s2_next.doy_e    = days_before(s1_reg.em);
        s2_next.feb_s    = (s1_reg.sm > MONTH_FEB) && leap_s;
        s2_next.feb_e    = (s1_reg.em > MONTH_FEB) && leap_e;
        s2_next.sd       = s1_reg.sd;
        s2_next.ed       = s1_reg.ed;
    end

    always_ff @(posedge clk)
    begin
        if (en2)
            s2_reg <= s2_next;
    end

    // ------------------------------------------------------------------
    // Stage 3: assemble both day ordinals and the leap year difference.
    // ------------------------------------------------------------------
    s3_t s3_reg, s3_next;

    always_comb
    begin
        s3_next.date_ok  = s2_reg.date_ok;
        s3_next.count_ok = s2_reg.date_ok && s2_reg.count_ok;
        s3_next.ord_s    = s2_reg.base_s + ORD_W'(s2_reg.lu_s) + ORD_W'(s2_reg.doy_s) +
                           ORD_W'(s2_reg.feb_s) + ORD_W'(s2_reg.sd);
        s3_next.ord_e    = s2_reg.base_e + ORD_W'(s2_reg.lu_e) + ORD_W'(s2_reg.doy_e) +
                           ORD_W'(s2_reg.feb_e) + ORD_W'(s2_reg.ed);
        s3_next.leaps    = s2_reg.lu_e - s2_reg.lu_s;
    end

    always_ff @(posedge clk)
    begin
        if (en3)
            s3_reg <= s3_next;
    end

    // ------------------------------------------------------------------
    // Stage 4: subtract, saturate, zero the counts for a failed check or an
    // end date ahead of the start, and hold the result for the master side.
    // ------------------------------------------------------------------
    logic [ORD_W-1:0]   diff;
    logic [DAYS_W-1:0]  days_next, days_reg;
    logic [LEAPS_W-1:0] leaps_next, leaps_reg;
    logic               ok_reg;

    always_comb
    begin
        diff       = s3_reg.ord_e - s3_reg.ord_s;
        days_next  = (diff > ORD_W'(DAYS_MAX)) ? DAYS_MAX : diff[DAYS_W-1:0];
        leaps_next = (s3_reg.leaps > LEAP_W'(LEAPS_MAX)) ? LEAPS_MAX :
                     s3_reg.leaps[LEAPS_W-1:0];
        if (!s3_reg.count_ok)
        begin
            days_next  = '0;
            leaps_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            days_reg  <= days_next;
            leaps_reg <= leaps_next;
            ok_reg    <= s3_reg.date_ok;
        end
    end

    assign m_axis_tdata = {(OUT_DATA_W-DAYS_W-LEAPS_W)'(0), leaps_reg, days_reg};
    assign m_axis_tuser = ok_reg;

endmodule

// ----- bench/date_day_count_tb.sv -----
module date_day_count_tb;

    localparam int YEAR_LIMIT   = 2100;
    localparam int RANDOM_ITEMS = 850;
    // Run the last stretch with both sides streaming back to back.
    localparam int QUIET_TAIL   = 120;
    localparam int CYCLE_LIMIT  = 200000;
    // Pipeline depth is four; after the last response, keep watching for strays.
    localparam int DRAIN_CYCLES = 12;
    localparam int MAX_PRINTS   = 100;

    localparam int DAY_W   = ddc_pkg::DAY_W;
    localparam int MONTH_W = ddc_pkg::MONTH_W;
    localparam int YEAR_W  = ddc_pkg::YEAR_W;
    localparam int DAYS_W  = ddc_pkg::DAYS_W;
    localparam int LEAPS_W = ddc_pkg::LEAPS_W;

    // One request: a start date and an end date, fields at the port widths.
    typedef struct packed {
        logic [ddc_pkg::DAY_W-1:0]   sd;
        logic [ddc_pkg::MONTH_W-1:0] sm;
        logic [ddc_pkg::YEAR_W-1:0]  sy;
        logic [ddc_pkg::DAY_W-1:0]   ed;
        logic [ddc_pkg::MONTH_W-1:0] em;
        logic [ddc_pkg::YEAR_W-1:0]  ey;
    } date_pair_t;

    // One response: start-date check plus the two counts.
    typedef struct packed {
        logic                        valid;
        logic [ddc_pkg::DAYS_W-1:0]  days;
        logic [ddc_pkg::LEAPS_W-1:0] leaps;
    } day_span_t;

    // A row of the directed table; pinned rows carry an answer typed in by hand.
    typedef struct {
        date_pair_t dates;
        bit         pinned;
        day_span_t  answer;
    } span_case_t;

    logic                           clk;
    logic                           rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [ddc_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [ddc_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                           m_axis_tuser;

    day_span_t  pending_spans[$];
    span_case_t span_cases[$];
    day_span_t  oldest_span;
    int         mismatches = 0;
    int         cycle_count = 0;
    int         idle_pct;
    bit         quiet;
    int         stall_left = 0;

    date_day_count #(
        .YEAR_LIMIT(YEAR_LIMIT)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Calendar arithmetic for the predictor
    // ------------------------------------------------------------------

    function automatic bit gregorian_leap(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // Leap years among 1..n.
    function automatic int unsigned leaps_through(input int unsigned n);
        return n / 4 - n / 100 + n / 400;
    endfunction

    function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
        case (m)
            4, 6, 9, 11: return 30;
            2:           return gregorian_leap(y) ? 29 : 28;
            default:     return 31;
        endcase
    endfunction

    // Days since the start of the calendar; y is at least 1, m is 1..12,
    // d is taken as given even when it runs past the month.
    function automatic int unsigned day_number(input int unsigned d, input int unsigned m,
                                               input int unsigned y);
        int unsigned n;
        n = 365 * (y - 1) + leaps_through(y - 1) + d;
        case (m)
            2:  n += 31;
            3:  n += 59;
            4:  n += 90;
            5:  n += 120;
            6:  n += 151;
            7:  n += 181;
            8:  n += 212;
            9:  n += 243;
            10: n += 273;
            11: n += 304;
            12: n += 334;
            default: ;
        endcase
        if (m > 2 && gregorian_leap(y))
            n += 1;
        return n;
    endfunction

    // Work out the response the block owes for one request.
    function automatic day_span_t predict_span(input date_pair_t q);
        day_span_t   r;
        int unsigned end_month;
        int unsigned days;
        int unsigned leaps;
        bit          end_first;
        r = '0;
        // Reject a bad start date outright: both counts stay zero.
        if (q.sy < 1 || q.sy >= YEAR_LIMIT || q.sm < 1 || q.sm > 12 ||
            q.sd < 1 || q.sd > month_length(q.sm, q.sy))
            return r;
        r.valid = 1'b1;
        // Clamp the end month into 1..12 for both the compare and the count.
        end_month = q.em;
        if (end_month < 1)
            end_month = 1;
        if (end_month > 12)
            end_month = 12;
        end_first = (q.ey < q.sy) ||
                    (q.ey == q.sy && end_month < q.sm) ||
                    (q.ey == q.sy && end_month == q.sm && q.ed < q.sd);
        if (end_first)
            return r;
        days  = day_number(q.ed, end_month, q.ey) - day_number(q.sd, q.sm, q.sy);
        leaps = leaps_through(q.ey - 1) - leaps_through(q.sy - 1);
        // Saturate both counts at the width of their output fields.
        r.days  = (days > ddc_pkg::DAYS_MAX) ? ddc_pkg::DAYS_MAX : days[ddc_pkg::DAYS_W-1:0];
        r.leaps = (leaps > ddc_pkg::LEAPS_MAX) ? ddc_pkg::LEAPS_MAX
                                               : leaps[ddc_pkg::LEAPS_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic add_case(input int sd, input int sm, input int sy,
                            input int ed, input int em, input int ey,
                            input bit pinned = 1'b0, input bit ok = 1'b0,
                            input int unsigned days = 0, input int unsigned leaps = 0);
        span_case_t c;
        c.dates  = '{DAY_W'(sd), MONTH_W'(sm), YEAR_W'(sy),
                     DAY_W'(ed), MONTH_W'(em), YEAR_W'(ey)};
        c.pinned = pinned;
        c.answer = '{ok, DAYS_W'(days), LEAPS_W'(leaps)};
        span_cases.push_back(c);
    endtask

    // Draw one request. Most carry a legal start date so the counting path
    // gets exercised; the rest are raw noise across every field.
    function automatic date_pair_t random_dates();
        date_pair_t  q;
        int          kind;
        logic [63:0] noise;
        kind = $urandom_range(0, 9);
        q.sy = YEAR_W'($urandom_range(1, YEAR_LIMIT - 1));
        q.sm = MONTH_W'($urandom_range(1, 12));
        q.sd = DAY_W'($urandom_range(1, month_length(q.sm, q.sy)));
        q.ey = YEAR_W'($urandom_range(q.sy, YEAR_LIMIT - 1));
        q.em = MONTH_W'($urandom_range(1, 12));
        q.ed = DAY_W'($urandom_range(1, month_length(q.em, q.ey)));
        case (kind)
            6:
            begin
                // Legal start, end fields anywhere in their bit range.
                q.ed = DAY_W'($urandom_range(0, 31));
                q.em = MONTH_W'($urandom_range(0, 15));
                q.ey = YEAR_W'($urandom_range(0, 4095));
            end
            7:
            begin
                // Late February start, end in the same year: near-equal dates.
                q.sm = ddc_pkg::MONTH_FEB;
                q.sd = DAY_W'($urandom_range(27, month_length(q.sm, q.sy)));
                q.ey = q.sy;
                q.em = MONTH_W'($urandom_range(1, 3));
                q.ed = DAY_W'($urandom_range(1, month_length(q.em, q.ey)));
            end
            8, 9:
            begin
                noise = {$urandom, $urandom};
                q = noise[$bits(date_pair_t)-1:0];
            end
            default: ;
        endcase
        return q;
    endfunction

    // Present one request, hold it until the block takes it, then file the
    // response it owes.
    task automatic send_request(input date_pair_t q, input bit pinned, input day_span_t answer);
        if (!quiet && $urandom_range(0, 99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, q.ey, q.em, q.ed, q.sy, q.sm, q.sd};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_spans.push_back(pinned ? answer : predict_span(q));
    endtask

    initial
    begin
        date_pair_t q;
        day_span_t  unused;
        int         k;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        idle_pct      = 30;
        quiet         = 1'b0;
        unused        = '0;

        // Directed table: bad start dates, leap-day edges, equal and reversed
        // dates, clamped end fields and both saturation limits.
        add_case(0, 1, 2000, 1, 1, 2001, 1, 0);                         // day zero
        add_case(31, 4, 2001, 1, 1, 2002, 1, 0);                        // April 31
        add_case(29, ddc_pkg::MONTH_FEB, 1900, 1, 3, 1900, 1, 0);       // no leap day in 1900
        add_case(30, ddc_pkg::MONTH_FEB, 2000, 1, 3, 2000, 1, 0);
        add_case(1, 0, 2000, 1, 1, 2001, 1, 0);                         // month zero
        add_case(1, 13, 2000, 1, 1, 2001, 1, 0);
        add_case(1, 15, 2000, 1, 1, 2001, 1, 0);
        add_case(1, 1, 0, 1, 1, 1, 1, 0);                               // year zero
        add_case(1, 1, YEAR_LIMIT, 1, 1, 2099, 1, 0);                   // year past limit
        add_case(31, 12, 4095, 1, 1, 1, 1, 0);
        add_case(1, 1, 1, 1, 1, 1, 1, 1);                               // same date, first day
        add_case(31, 12, 2099, 31, 12, 2099, 1, 1);                     // same date, last day
        add_case(1, 1, 1, 31, 15, 4095, 1, 1,
                 ddc_pkg::DAYS_MAX, ddc_pkg::LEAPS_MAX);                // both counts saturate
        add_case(15, 6, 2000, 14, 6, 2000, 1, 1);                       // end one day early
        add_case(15, 6, 2000, 31, 5, 2000, 1, 1);                       // end month early
        add_case(15, 6, 2000, 1, 1, 1999, 1, 1);                        // end year early
        add_case(1, 1, 1, 0, 0, 0, 1, 1);                               // end year zero
        add_case(1, 6, 2000, 0, 6, 2000, 1, 1);                         // end day zero, same month
        add_case(29, ddc_pkg::MONTH_FEB, 2000, 1, 3, 2000);
        add_case(29, ddc_pkg::MONTH_FEB, 2024, 29, 2, 2028);
        add_case(28, ddc_pkg::MONTH_FEB, 1900, 1, 3, 1900);
        add_case(31, 1, 2000, 31, 12, 2000);                            // long month in a 400 year
        add_case(30, 4, 2000, 1, 5, 2000);
        add_case(1, 1, 1, 31, ddc_pkg::MONTH_DEC, 2099);
        add_case(15, 6, 2000, 0, 0, 2001);                              // end month clamps up
        add_case(15, 6, 2000, 31, 14, 2001);                            // end month clamps down
        add_case(31, 12, 2099, 31, 12, 4095);

        // Hold reset low, then release it on a rising edge.
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (span_cases[i])
            send_request(span_cases[i].dates, span_cases[i].pinned, span_cases[i].answer);

        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            // Change the idle mix every 64 requests; zero gives clean stretches.
            if (k % 64 == 0)
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 15;
                    default: idle_pct = 45;
                endcase
            if (k == RANDOM_ITEMS - QUIET_TAIL)
                quiet = 1'b1;
            q = random_dates();
            send_request(q, 1'b0, unused);
        end
        s_axis_tvalid <= 1'b0;

        // Drain: wait for every owed response, then watch for strays.
        while (pending_spans.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Response side
    // ------------------------------------------------------------------

    // Stall the master side in random bursts; never in the quiet tail.
    always @(posedge clk)
    begin
        if (quiet)
            m_axis_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < idle_pct)
        begin
            stall_left    <= $urandom_range(0, 6);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("cycle %0d: %s mismatch, got %0d, want %0d",
                     cycle_count, what, got, want);
    endtask

    // Compare each response, field by field, with the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_spans.size() == 0)
                report_mismatch("unrequested response", m_axis_tdata, 0);
            else
            begin
                oldest_span = pending_spans.pop_front();
                if (m_axis_tuser !== oldest_span.valid)
                    report_mismatch("valid_res", m_axis_tuser, oldest_span.valid);
                if (m_axis_tdata[19:0] !== oldest_span.days)
                    report_mismatch("elapsed_days", m_axis_tdata[19:0], oldest_span.days);
                if (m_axis_tdata[28:20] !== oldest_span.leaps)
                    report_mismatch("leap_years_passed", m_axis_tdata[28:20],
                                    oldest_span.leaps);
                if (m_axis_tdata[31:29] !== 3'b000)
                    report_mismatch("tdata fill", m_axis_tdata[31:29], 0);
            end
        end
    end

    // Abort a run that reaches the cycle limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule

// ----- sim.f -----
hw/rtl/ddc_pkg.sv
hw/rtl/date_day_count.sv
bench/date_day_count_tb.sv
